// ===== rtl/core/lqz_pkg.sv =====
package lqz_pkg;

   // Field and internal widths
   localparam int LON_W      = 39;
   localparam int LAT_W      = 38;
   localparam int BOUND_W    = 31;
   localparam int STEP_W     = 32;
   localparam int PRED_W     = 41;
   localparam int DIFF_W     = 42;
   localparam int CODE_W     = 42;
   localparam int RECON_W    = 39;
   localparam int NUM_W      = 43;
   localparam int SUM_W      = 45;
   localparam int SQ_IN_W    = 32;
   localparam int ESQ_W      = 64;
   localparam int PHASE_W    = 2;
   localparam int CNT_W      = 6;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 312;

   localparam logic [BOUND_W-1:0] BOUND_RESET = 31'd10727;

   // Stream position codes
   localparam logic [PHASE_W-1:0] PHASE_FIRST  = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_SECOND = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_EXTRAP = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREDICT,
      ST_RESID,
      ST_DIV_START,
      ST_DIVIDE,
      ST_SQ_LON,
      ST_SQ_LAT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic predict;
      logic resid;
      logic div_start;
      logic sq_lon;
      logic sq_lat;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic slot_free;
   } status_type;

endpackage

// ===== rtl/core/lqz_div.sv =====
module lqz_div
   import lqz_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUM_W-1:0]   dividend,
   input  logic [STEP_W-1:0]  divisor,
   output logic               done,
   output logic [NUM_W-1:0]   quotient,
   output logic [STEP_W-1:0]  remainder
);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [STEP_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0]   quo_ff, quo_in;
   logic [STEP_W:0]    trial;
   logic [STEP_W+1:0]  diff;
   logic               fits;

   // One restoring step per cycle, dividend bits shift out as quotient bits shift in
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      diff    = {1'b0, trial} - {2'b00, divisor};
      fits    = !diff[STEP_W+1];
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Partial remainder and quotient
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

`ifndef SYNTH
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < divisor))
      else $error("partial remainder not below divisor");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("done without a finished run");
`endif

endmodule

// ===== rtl/core/lqz_datapath.sv =====
module lqz_datapath
   import lqz_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 30
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [LON_W-1:0]     req_longitude,
   input  logic [LAT_W-1:0]     req_latitude,
   input  logic                 csr_valid,
   input  logic [BOUND_W-1:0]   csr_data,
   input  logic                 rsp_tready,
   output logic                 rsp_tvalid,
   output logic [PHASE_W-1:0]   rsp_phase,
   output logic [PRED_W-1:0]    rsp_pred_lon,
   output logic [PRED_W-1:0]    rsp_pred_lat,
   output logic [CODE_W-1:0]    rsp_code_lon,
   output logic [CODE_W-1:0]    rsp_code_lat,
   output logic [RECON_W-1:0]   rsp_recon_lon,
   output logic [RECON_W-1:0]   rsp_recon_lat,
   output logic                 rsp_within_bound,
   output logic [ESQ_W-1:0]     rsp_error_sq
);

   localparam logic [PRED_W-1:0]  BASE_PRED = PRED_W'(2) << COORD_FRAC_BITS;
   localparam logic [RECON_W-1:0] RECON_MAX = {1'b0, {(RECON_W-1){1'b1}}};
   localparam logic [RECON_W-1:0] RECON_MIN = {1'b1, {(RECON_W-1){1'b0}}};

   // Pick the prediction for the point's place in the stream
   function automatic logic [PRED_W-1:0] extrapolate(
      input logic [PHASE_W-1:0] ph,
      input logic [RECON_W-1:0] last,
      input logic [RECON_W-1:0] prior
   );
      logic [PRED_W-1:0] last_x;
      logic [PRED_W-1:0] prior_x;
      logic [PRED_W-1:0] res;
      last_x  = {{(PRED_W-RECON_W){last[RECON_W-1]}}, last};
      prior_x = {{(PRED_W-RECON_W){prior[RECON_W-1]}}, prior};
      unique case (ph)
         PHASE_FIRST:  res = BASE_PRED;
         PHASE_SECOND: res = last_x;
         default:      res = {last_x[PRED_W-2:0], 1'b0} - prior_x;
      endcase
      return res;
   endfunction

   // Apply the signed step multiple to the prediction and clamp
   function automatic logic [RECON_W-1:0] reconstruct(
      input logic [PRED_W-1:0] pred,
      input logic [NUM_W-1:0]  prod,
      input logic              neg
   );
      logic [SUM_W-1:0]   p;
      logic [SUM_W-1:0]   m;
      logic [SUM_W-1:0]   s;
      logic [RECON_W-1:0] res;
      p = {{(SUM_W-PRED_W){pred[PRED_W-1]}}, pred};
      m = {{(SUM_W-NUM_W){1'b0}}, prod};
      s = neg ? (p - m) : (p + m);
      priority if (!s[SUM_W-1] && (|s[SUM_W-2:RECON_W-1])) begin
         res = RECON_MAX;
      end else if (s[SUM_W-1] && !(&s[SUM_W-2:RECON_W-1])) begin
         res = RECON_MIN;
      end else begin
         res = s[RECON_W-1:0];
      end
      return res;
   endfunction

   logic [BOUND_W-1:0]  error_bound_ff;
   logic [BOUND_W-1:0]  e_ff;
   logic [PHASE_W-1:0]  points_seen_ff;
   logic [PHASE_W-1:0]  phase_ff;
   logic [LON_W-1:0]    lon_ff;
   logic [LAT_W-1:0]    lat_ff;
   logic [RECON_W-1:0]  last_lon_ff, prior_lon_ff, last_lat_ff, prior_lat_ff;
   logic [PRED_W-1:0]   pred_lon_ff, pred_lat_ff;
   logic [DIFF_W-1:0]   mag_lon_ff, mag_lat_ff;
   logic                neg_lon_ff, neg_lat_ff;
   logic [NUM_W-1:0]    num_lon_ff, num_lat_ff;
   logic [NUM_W-1:0]    prod_lon_ff, prod_lat_ff;
   logic [ESQ_W-1:0]    sqx_ff, sqy_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [DIFF_W-1:0]   a_lon_x, a_lat_x, p_lon_x, p_lat_x;
   logic [DIFF_W-1:0]   dpos_lon, dneg_lon, dpos_lat, dneg_lat;
   logic [NUM_W-1:0]    num_lon, num_lat;
   logic [STEP_W-1:0]   step;
   logic                done_lon, done_lat;
   logic [NUM_W-1:0]    quo_lon, quo_lat;
   logic [STEP_W-1:0]   rem_lon, rem_lat;
   logic [DIFF_W-1:0]   sq_src;
   logic [SQ_IN_W-1:0]  sq_lo;
   logic                sq_over;
   logic [ESQ_W-1:0]    sq_prod;
   logic [ESQ_W-1:0]    sq_val;
   logic [ESQ_W:0]      esq_sum;
   logic [NUM_W-1:0]    code_lon_full, code_lat_full;
   logic                extrap;
   logic [RECON_W-1:0]  recon_lon, recon_lat;

   // Residual magnitude and sign, both differences in parallel
   always_comb begin
      a_lon_x  = {{(DIFF_W-LON_W){lon_ff[LON_W-1]}}, lon_ff};
      a_lat_x  = {{(DIFF_W-LAT_W){lat_ff[LAT_W-1]}}, lat_ff};
      p_lon_x  = {{(DIFF_W-PRED_W){pred_lon_ff[PRED_W-1]}}, pred_lon_ff};
      p_lat_x  = {{(DIFF_W-PRED_W){pred_lat_ff[PRED_W-1]}}, pred_lat_ff};
      dpos_lon = a_lon_x - p_lon_x;
      dneg_lon = p_lon_x - a_lon_x;
      dpos_lat = a_lat_x - p_lat_x;
      dneg_lat = p_lat_x - a_lat_x;
   end

   // Divider operands: |r| + e over 2e
   assign num_lon = {1'b0, mag_lon_ff} + NUM_W'(e_ff);
   assign num_lat = {1'b0, mag_lat_ff} + NUM_W'(e_ff);
   assign step    = {e_ff, 1'b0};

   lqz_div u_div_lon (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (num_lon),
      .divisor   (step),
      .done      (done_lon),
      .quotient  (quo_lon),
      .remainder (rem_lon)
   );

   lqz_div u_div_lat (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (num_lat),
      .divisor   (step),
      .done      (done_lat),
      .quotient  (quo_lat),
      .remainder (rem_lat)
   );

   // Shared saturating squarer
   always_comb begin
      sq_src  = cmd.sq_lat ? mag_lat_ff : mag_lon_ff;
      sq_lo   = sq_src[SQ_IN_W-1:0];
      sq_over = |sq_src[DIFF_W-1:SQ_IN_W];
      sq_prod = sq_lo * sq_lo;
      sq_val  = sq_over ? {ESQ_W{1'b1}} : sq_prod;
   end

   // Result assembly
   always_comb begin
      extrap        = (phase_ff == PHASE_EXTRAP);
      esq_sum       = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      code_lon_full = neg_lon_ff ? (NUM_W'(0) - quo_lon) : quo_lon;
      code_lat_full = neg_lat_ff ? (NUM_W'(0) - quo_lat) : quo_lat;
      recon_lon     = reconstruct(pred_lon_ff, prod_lon_ff, neg_lon_ff);
      recon_lat     = reconstruct(pred_lat_ff, prod_lat_ff, neg_lat_ff);
      rsp_valid_in  = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Bound register, history and position counter
   always_ff @(posedge clock) begin
      if (reset) begin
         error_bound_ff <= BOUND_RESET;
         points_seen_ff <= PHASE_FIRST;
         last_lon_ff    <= '0;
         prior_lon_ff   <= '0;
         last_lat_ff    <= '0;
         prior_lat_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            error_bound_ff <= csr_data;
         end
         if (cmd.emit) begin
            prior_lon_ff <= last_lon_ff;
            last_lon_ff  <= recon_lon;
            prior_lat_ff <= last_lat_ff;
            last_lat_ff  <= recon_lat;
            if (points_seen_ff != PHASE_EXTRAP) begin
               points_seen_ff <= points_seen_ff + 1'b1;
            end
         end
      end
   end

   // Working registers, advanced by the controller's commands
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         lon_ff   <= req_longitude;
         lat_ff   <= req_latitude;
         phase_ff <= points_seen_ff;
         e_ff     <= (error_bound_ff == '0) ? BOUND_W'(1) : error_bound_ff;
      end
      if (cmd.predict) begin
         pred_lon_ff <= extrapolate(phase_ff, last_lon_ff, prior_lon_ff);
         pred_lat_ff <= extrapolate(phase_ff, last_lat_ff, prior_lat_ff);
      end
      if (cmd.resid) begin
         neg_lon_ff <= dpos_lon[DIFF_W-1];
         mag_lon_ff <= dpos_lon[DIFF_W-1] ? dneg_lon : dpos_lon;
         neg_lat_ff <= dpos_lat[DIFF_W-1];
         mag_lat_ff <= dpos_lat[DIFF_W-1] ? dneg_lat : dpos_lat;
      end
      if (cmd.div_start) begin
         num_lon_ff <= num_lon;
         num_lat_ff <= num_lat;
      end
      if (cmd.sq_lon) begin
         sqx_ff      <= sq_val;
         prod_lon_ff <= num_lon_ff - NUM_W'(rem_lon);
         prod_lat_ff <= num_lat_ff - NUM_W'(rem_lat);
      end
      if (cmd.sq_lat) begin
         sqy_ff <= sq_val;
      end
      if (cmd.emit) begin
         rsp_phase        <= phase_ff;
         rsp_pred_lon     <= extrap ? pred_lon_ff : '0;
         rsp_pred_lat     <= extrap ? pred_lat_ff : '0;
         rsp_code_lon     <= code_lon_full[CODE_W-1:0];
         rsp_code_lat     <= code_lat_full[CODE_W-1:0];
         rsp_recon_lon    <= recon_lon;
         rsp_recon_lat    <= recon_lat;
         rsp_within_bound <= extrap && (mag_lon_ff <= DIFF_W'(e_ff))
                                    && (mag_lat_ff <= DIFF_W'(e_ff));
         rsp_error_sq     <= !extrap ? '0 :
                             (esq_sum[ESQ_W] ? {ESQ_W{1'b1}} : esq_sum[ESQ_W-1:0]);
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign status.div_done  = done_lon & done_lat;
   assign status.slot_free = !rsp_valid_ff || rsp_tready;

endmodule

// ===== rtl/core/lqz_ctrl.sv =====
module lqz_ctrl
   import lqz_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  status_type  status,
   output cmd_type     cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one item through predict, divide, square and emit
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_PREDICT;
            end
         end
         ST_PREDICT: begin
            cmd.predict = 1'b1;
            state_in    = ST_RESID;
         end
         ST_RESID: begin
            cmd.resid = 1'b1;
            state_in  = ST_DIV_START;
         end
         ST_DIV_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_SQ_LON;
            end
         end
         ST_SQ_LON: begin
            cmd.sq_lon = 1'b1;
            state_in   = ST_SQ_LAT;
         end
         ST_SQ_LAT: begin
            cmd.sq_lat = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register can take the item
            if (status.slot_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/linear_extrapolation_quantizer_unit.sv =====
// An accepted req item passes through predict, residual, two 43-step radix-2
//   dividers (one per coordinate), two squaring steps and emit before rsp_tvalid.
// One item at a time; req_tready rises the cycle after the result
//   is loaded into the output register, which holds it until rsp_tready.
// Reset: synchronous, active high; clears history and position count, bound to 10727.
module linear_extrapolation_quantizer_unit
   import lqz_pkg::*;
#(
   parameter int COORD_FRAC_BITS = 30
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // longitude[38:0], latitude[76:39], zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,   // pred_lon, pred_lat, code_lon, code_lat,
                                               // recon_lon, recon_lat, within_bound,
                                               // error_sq, zero pad
   output logic [PHASE_W-1:0]     rsp_tuser,   // phase
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [BOUND_W-1:0]     csr_data     // error_bound
);

   cmd_type             cmd;
   status_type          status;
   logic [PRED_W-1:0]   pred_lon, pred_lat;
   logic [CODE_W-1:0]   code_lon, code_lat;
   logic [RECON_W-1:0]  recon_lon, recon_lat;
   logic                within_bound;
   logic [ESQ_W-1:0]    error_sq;

   lqz_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lqz_datapath #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_longitude    (req_tdata[LON_W-1:0]),
      .req_latitude     (req_tdata[LON_W+LAT_W-1:LON_W]),
      .csr_valid        (csr_valid),
      .csr_data         (csr_data),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_phase        (rsp_tuser),
      .rsp_pred_lon     (pred_lon),
      .rsp_pred_lat     (pred_lat),
      .rsp_code_lon     (code_lon),
      .rsp_code_lat     (code_lat),
      .rsp_recon_lon    (recon_lon),
      .rsp_recon_lat    (recon_lat),
      .rsp_within_bound (within_bound),
      .rsp_error_sq     (error_sq)
   );

   // Bound register takes a write in any cycle
   assign csr_ready = 1'b1;

   // Pack result fields, lowest first
   assign rsp_tdata = {3'b000, error_sq, within_bound, recon_lat, recon_lon,
                       code_lat, code_lon, pred_lat, pred_lon};

endmodule
